/* src/bfe_pkg.sv */
`default_nettype none

package bfe_pkg;

    localparam int TOKEN_W   = 32;
    localparam int COUNT_W   = 10;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam int unsigned COUNT_MAX = 1023;

    localparam logic [CFG_IDX_W-1:0] REG_QUERY_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_SECOND = 2'd1;

    typedef struct packed {
        logic [TOKEN_W-1:0] token;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic [TOKEN_W-1:0] best_first;
        logic [TOKEN_W-1:0] best_second;
        logic [COUNT_W-1:0] best_count;
        logic [COUNT_W-1:0] query_count;
        logic [COUNT_W-1:0] pair_total;
        logic               found;
        logic               overflow;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CAND0,
        ST_CAND1,
        ST_CAND2,
        ST_SWEEP,
        ST_EVAL,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

/* src/bfe_in_if.sv */
`default_nettype none

interface bfe_in_if;
    import bfe_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* src/bfe_out_if.sv */
`default_nettype none

interface bfe_out_if;
    import bfe_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* src/bfe_ram.sv */
`default_nettype none

module bfe_ram #(
    parameter int W = 32,
    parameter int D = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

/* src/bigram_frequency_engine_top.sv */
`default_nettype none

// bigram frequency engine: tokens are written into a DEPTH-entry token memory at one per
// cycle while the block is loading. a transfer with last set starts the search; input
// ready then stays low until the result is handed to the output register. with n stored
// tokens (n >= 2) the search time grows with the square of n, set by the single read
// port of the token memory and the one pair comparator that sweeps the whole sequence
// once for the query pair and once per candidate pair. with fewer than two tokens no
// sweep is run. tokens arriving with the memory full are dropped and reported through
// overflow. the result waits in an output register, so loading of the next sequence
// may start before it is taken.
module bigram_frequency_engine_top #(
    parameter int DEPTH      = 1024,
    parameter int TOKEN_BITS = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [bfe_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [bfe_pkg::CFG_W-1:0]   i_cfg_data,
    bfe_in_if.sink                           i_in,
    bfe_out_if.source                        o_res
);
    import bfe_pkg::*;

    // stored token width: result bits above SW are always zero
    localparam int SW = (TOKEN_BITS < TOKEN_W) ? TOKEN_BITS : TOKEN_W;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [COUNT_W-1:0] sat_cnt(input logic [CW-1:0] c);
        logic [COUNT_W-1:0] res;
        if (32'(c) > 32'(COUNT_MAX)) begin
            res = COUNT_W'(COUNT_MAX);
        end else begin
            res = COUNT_W'(c);
        end
        return res;
    endfunction

    t_state r_state, n_state;

    // configuration
    logic [CFG_W-1:0] r_qf, r_qs;

    // sequence bookkeeping
    logic [CW-1:0] r_fill;
    logic          r_drop;

    // search datapath
    logic [SW-1:0] r_cand_a, r_cand_b;
    logic [SW-1:0] r_prev;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_k;
    logic          r_rv;
    logic          r_rfirst;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_qcnt;
    logic          r_qmode;
    logic [CW-1:0] r_best_c;
    logic [SW-1:0] r_best_a, r_best_b;

    // output register
    logic      r_ovalid;
    t_out_item r_out;

    // memory port
    logic          w_we;
    logic [AW-1:0] w_raddr;
    logic [SW-1:0] w_rdata;

    logic          w_room;
    logic          w_accept;
    logic [CW-1:0] w_fill_new;
    logic [CW-1:0] w_i1;
    logic [CW-1:0] w_i2;
    logic          w_issue;
    logic          w_match;
    logic          w_out_free;
    logic          w_found;

    assign w_room     = r_fill < CW'(DEPTH);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_fill_new = r_fill + CW'(w_room);
    assign w_i1       = r_i + CW'(1);
    assign w_i2       = r_i + CW'(2);
    assign w_issue    = r_k < r_fill;
    // the one shared pair comparator
    assign w_match    = (r_prev == r_cand_a) && (w_rdata == r_cand_b);
    assign w_out_free = !r_ovalid || o_res.ready;
    assign w_found    = r_fill >= CW'(2);

    bfe_ram #(
        .W (SW),
        .D (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (i_in.payload.token[SW-1:0]),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (w_accept && i_in.payload.last) begin
                    n_state = (w_fill_new >= CW'(2)) ? ST_SWEEP : ST_FIN;
                end
            end
            ST_CAND0: n_state = ST_CAND1;
            ST_CAND1: n_state = ST_CAND2;
            ST_CAND2: n_state = ST_SWEEP;
            ST_SWEEP: begin
                if (!w_issue && !r_rv) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (r_qmode) begin
                    n_state = ST_CAND0;
                end else if (w_i2 < r_fill) begin
                    n_state = ST_CAND0;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // control outputs
    always_comb begin
        i_in.ready = 1'b0;
        w_we       = 1'b0;
        w_raddr    = r_k[AW-1:0];
        case (r_state)
            ST_LOAD: begin
                i_in.ready = 1'b1;
                w_we       = i_in.valid && w_room;
            end
            ST_CAND0: w_raddr = r_i[AW-1:0];
            ST_CAND1: w_raddr = w_i1[AW-1:0];
            default: w_raddr = r_k[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_qf     <= '0;
            r_qs     <= '0;
            r_fill   <= '0;
            r_drop   <= 1'b0;
            r_rv     <= 1'b0;
            r_qmode  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_QUERY_FIRST:  r_qf <= i_cfg_data;
                    REG_QUERY_SECOND: r_qs <= i_cfg_data;
                    default: ;
                endcase
            end

            // a new result refills the register in the cycle the old one leaves
            if (r_state == ST_FIN && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                ST_LOAD: begin
                    if (w_accept) begin
                        if (w_room) begin
                            r_fill <= w_fill_new;
                        end else begin
                            r_drop <= 1'b1;
                        end
                        if (i_in.payload.last) begin
                            // first sweep counts the query pair
                            r_cand_a <= r_qf[SW-1:0];
                            r_cand_b <= r_qs[SW-1:0];
                            r_qmode  <= 1'b1;
                            r_k      <= '0;
                            r_rv     <= 1'b0;
                            r_cnt    <= '0;
                            r_qcnt   <= '0;
                            r_best_c <= '0;
                            r_best_a <= '0;
                            r_best_b <= '0;
                            r_i      <= '0;
                        end
                    end
                end
                ST_CAND1: r_cand_a <= w_rdata;
                ST_CAND2: begin
                    r_cand_b <= w_rdata;
                    r_k      <= '0;
                    r_rv     <= 1'b0;
                    r_cnt    <= '0;
                end
                ST_SWEEP: begin
                    // one read issued, one token consumed per cycle
                    if (w_issue) begin
                        r_k      <= r_k + CW'(1);
                        r_rv     <= 1'b1;
                        r_rfirst <= (r_k == '0);
                    end else begin
                        r_rv <= 1'b0;
                    end
                    if (r_rv) begin
                        r_prev <= w_rdata;
                        if (!r_rfirst && w_match) begin
                            r_cnt <= r_cnt + CW'(1);
                        end
                    end
                end
                ST_EVAL: begin
                    if (r_qmode) begin
                        r_qcnt  <= r_cnt;
                        r_qmode <= 1'b0;
                        r_i     <= '0;
                    end else begin
                        // strict compare keeps the earliest pair on a tie
                        if (r_cnt > r_best_c) begin
                            r_best_c <= r_cnt;
                            r_best_a <= r_cand_a;
                            r_best_b <= r_cand_b;
                        end
                        r_i <= w_i1;
                    end
                end
                ST_FIN: begin
                    if (w_out_free) begin
                        r_out.found         <= w_found;
                        r_out.overflow      <= r_drop;
                        r_out.best_first    <= TOKEN_W'(r_best_a);
                        r_out.best_second   <= TOKEN_W'(r_best_b);
                        r_out.best_count    <= sat_cnt(r_best_c);
                        r_out.query_count   <= sat_cnt(r_qcnt);
                        r_out.pair_total    <= w_found ? sat_cnt(r_fill - CW'(1)) : '0;
                        r_fill              <= '0;
                        r_drop              <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_res.valid   = r_ovalid;
    assign o_res.payload = r_out;
endmodule

`default_nettype wire

/* tb/tb.sv */
`default_nettype none

module tb;
    import bfe_pkg::*;

    localparam int SEQ_DEPTH = 1024;

    // register indexes the block does not decode; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // token alphabets for generated sequences
    localparam int unsigned ALPHA_TINY    = 0;
    localparam int unsigned ALPHA_NIBBLE  = 1;
    localparam int unsigned ALPHA_EXTREME = 2;
    localparam int unsigned ALPHA_FULL    = 3;
    localparam int unsigned ALPHA_MIXED   = 4;

    // receiver back-pressure: one long hold once this many results have been taken
    localparam int unsigned HOLD_AT  = 30;
    localparam int unsigned HOLD_LEN = 500;

    localparam int unsigned PHASE_ITEMS = 140;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    bfe_in_if  in_if ();
    bfe_out_if res_if ();

    bigram_frequency_engine_top #(
        .DEPTH      (SEQ_DEPTH),
        .TOKEN_BITS (TOKEN_W)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_res      (res_if)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // bigram predictor: own copy of the token sequence and query registers
    // ------------------------------------------------------------------
    logic [TOKEN_W-1:0] seq_mem [SEQ_DEPTH];
    int unsigned        seq_fill;
    bit                 seq_dropped;
    logic [TOKEN_W-1:0] query_a;
    logic [TOKEN_W-1:0] query_b;

    t_in_item  token_q [$];     // tokens waiting to be offered
    t_out_item summary_q [$];   // predicted sequence summaries, oldest first

    int unsigned mismatches   = 0;
    int unsigned tokens_sent  = 0;
    int unsigned results_seen = 0;
    int unsigned seqs_queued  = 0;
    int unsigned query_sets   = 0;

    // occurrences of pair (a, b) among the first n stored tokens
    function automatic int unsigned count_pair(logic [TOKEN_W-1:0] a, logic [TOKEN_W-1:0] b,
                                               int unsigned n);
        int unsigned c;
        int unsigned k;
        c = 0;
        for (k = 0; k + 1 < n; k++) begin
            if (seq_mem[k] == a && seq_mem[k + 1] == b) c++;
        end
        return c;
    endfunction

    function automatic logic [COUNT_W-1:0] clamp_count(int unsigned c);
        return (c > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : c[COUNT_W-1:0];
    endfunction

    // store one accepted token; on last, predict the summary and clear the sequence
    task automatic absorb_token(t_in_item it);
        t_out_item   r;
        int unsigned hits;
        int unsigned top;
        int unsigned i;
        if (seq_fill < SEQ_DEPTH) begin
            seq_mem[seq_fill] = it.token;
            seq_fill++;
        end else begin
            seq_dropped = 1'b1;
        end
        if (it.last) begin
            r = '0;
            if (seq_fill >= 2) begin
                top = 0;
                // strict greater-than keeps the pair that shows up first on a tie
                for (i = 0; i + 1 < seq_fill; i++) begin
                    hits = count_pair(seq_mem[i], seq_mem[i + 1], seq_fill);
                    if (hits > top) begin
                        top           = hits;
                        r.best_first  = seq_mem[i];
                        r.best_second = seq_mem[i + 1];
                    end
                end
                r.best_count  = clamp_count(top);
                r.query_count = clamp_count(count_pair(query_a, query_b, seq_fill));
                r.pair_total  = clamp_count(seq_fill - 1);
                r.found       = 1'b1;
            end
            r.overflow = seq_dropped;
            summary_q.push_back(r);
            seq_fill    = 0;
            seq_dropped = 1'b0;
        end
    endtask

    // query registers follow the write port exactly as the block sees it
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            query_a <= '0;
            query_b <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_QUERY_FIRST: begin
                    query_a <= i_cfg_data[TOKEN_W-1:0];
                end
                REG_QUERY_SECOND: begin
                    query_b <= i_cfg_data[TOKEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // idle gaps: mostly short, a few long, with calm stretches of none
    // ------------------------------------------------------------------
    function automatic int unsigned draw_gap(inout int unsigned calm);
        int unsigned r;
        if (calm != 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 8) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // token driver
    // ------------------------------------------------------------------
    int unsigned src_gap;
    int unsigned src_calm = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid   <= 1'b0;
            in_if.payload <= '0;
            src_gap       <= 0;
            seq_fill       = 0;
            seq_dropped    = 1'b0;
        end else begin
            // transfer of a token: feed the predictor
            if (in_if.valid && in_if.ready) begin
                absorb_token(in_if.payload);
                tokens_sent <= tokens_sent + 1;
            end
            // slot is free when nothing is offered or the offer was just taken
            if (!in_if.valid || in_if.ready) begin
                if (src_gap != 0) begin
                    src_gap     <= src_gap - 1;
                    in_if.valid <= 1'b0;
                end else if (token_q.size() != 0) begin
                    in_if.valid   <= 1'b1;
                    in_if.payload <= token_q.pop_front();
                    src_gap       <= draw_gap(src_calm);
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor and checker
    // ------------------------------------------------------------------
    int unsigned sink_gap;
    int unsigned sink_calm = 0;
    int unsigned hold_left;
    bit          hold_done;

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic compare_field(string name, logic [TOKEN_W-1:0] got,
                                 logic [TOKEN_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    task automatic check_summary(t_out_item got);
        t_out_item want;
        if (summary_q.size() == 0) begin
            report_mismatch("result with no sequence pending");
        end else begin
            want = summary_q.pop_front();
            compare_field("best_first",  got.best_first,  want.best_first);
            compare_field("best_second", got.best_second, want.best_second);
            compare_field("best_count",  got.best_count,  want.best_count);
            compare_field("query_count", got.query_count, want.query_count);
            compare_field("pair_total",  got.pair_total,  want.pair_total);
            compare_field("found",       got.found,       want.found);
            compare_field("overflow",    got.overflow,    want.overflow);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            sink_gap     <= 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                check_summary(res_if.payload);
                results_seen <= results_seen + 1;
            end
            // long hold wins over the ordinary random gaps
            if (hold_left != 0) begin
                res_if.ready <= 1'b0;
            end else if (sink_gap != 0) begin
                sink_gap     <= sink_gap - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                sink_gap     <= draw_gap(sink_calm);
            end
        end
    end

    // one long receiver hold while the driver keeps offering, so the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && results_seen == HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_token(logic [TOKEN_W-1:0] tok, logic last);
        t_in_item it;
        it.token = tok;
        it.last  = last;
        token_q.push_back(it);
        if (last) seqs_queued++;
    endtask

    function automatic logic [TOKEN_W-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 32'h0000_0001;
            2:       return 32'h8000_0000;
            3:       return 32'h7fff_ffff;
            default: return '1;
        endcase
    endfunction

    // random sequence of len tokens drawn from one alphabet, last on the final token
    task automatic queue_sequence(int unsigned len, int unsigned alpha);
        int unsigned        k;
        logic [TOKEN_W-1:0] tok;
        for (k = 0; k < len; k++) begin
            case (alpha)
                ALPHA_TINY:    tok = $urandom_range(0, 3);
                ALPHA_NIBBLE:  tok = $urandom_range(0, 15);
                ALPHA_EXTREME: tok = pick_extreme();
                ALPHA_FULL:    tok = $urandom;
                default:       tok = ($urandom_range(0, 4) == 0) ? pick_extreme()
                                                                : $urandom_range(0, 3);
            endcase
            queue_token(tok, k + 1 == len);
        end
    endtask

    // wait until every token is sent and every summary has come back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (token_q.size() != 0 || in_if.valid || summary_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned        ph;
        int unsigned        queued;
        int unsigned        len;
        int unsigned        r;
        logic [TOKEN_W-1:0] qa;
        logic [TOKEN_W-1:0] qb;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        in_if.valid    = 1'b0;
        in_if.payload  = '0;
        res_if.ready   = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, query still at its reset value (0, 0)
        @(negedge i_clk);
        queue_token('0, 1'b1);                 // single token: no pair at all
        queue_token('1, 1'b1);
        queue_token('0, 1'b0);                 // overlapping (0, 0) pairs hit the query
        queue_token('0, 1'b0);
        queue_token('0, 1'b1);
        queue_token('1, 1'b0);                 // exactly one pair, extreme values
        queue_token('0, 1'b1);
        // tie between (3, 4) and (1, 2): the one seen first must win
        queue_token(32'd3, 1'b0);
        queue_token(32'd4, 1'b0);
        queue_token(32'd1, 1'b0);
        queue_token(32'd2, 1'b0);
        queue_token(32'd1, 1'b0);
        queue_token(32'd2, 1'b0);
        queue_token(32'd3, 1'b0);
        queue_token(32'd4, 1'b1);
        wait_drained();

        // extreme query, plus writes to undecoded indexes that must be ignored
        write_reg(REG_QUERY_FIRST, '1);
        write_reg(REG_QUERY_SECOND, '0);
        write_reg(REG_SPARE_A, $urandom);
        write_reg(REG_SPARE_B, '1);
        query_sets++;
        @(negedge i_clk);
        queue_token('1, 1'b0);
        queue_token('0, 1'b0);
        queue_token('1, 1'b0);
        queue_token('0, 1'b0);
        queue_token(32'd5, 1'b1);
        queue_token(32'd9, 1'b0);              // run of one value: every pair overlaps
        queue_token(32'd9, 1'b0);
        queue_token(32'd9, 1'b0);
        queue_token(32'd9, 1'b1);
        wait_drained();

        // random phases, each under its own query pair
        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    qa = '0;
                    qb = '0;
                end
                1: begin
                    qa = '1;
                    qb = '1;
                end
                2: begin
                    qa = '0;
                    qb = '1;
                end
                3: begin
                    qa = $urandom_range(0, 3);
                    qb = $urandom_range(0, 3);
                end
                default: begin
                    qa = $urandom;
                    qb = $urandom;
                end
            endcase
            write_reg(REG_QUERY_FIRST, qa);
            write_reg(REG_QUERY_SECOND, qb);
            if (ph == 4) write_reg(REG_SPARE_A, $urandom);
            query_sets++;

            @(negedge i_clk);
            queued = 0;
            while (queued < PHASE_ITEMS) begin
                // mostly short sequences: the search time grows with the square of length
                r = $urandom_range(0, 99);
                if (r < 70)      len = $urandom_range(1, 8);
                else if (r < 95) len = $urandom_range(9, 24);
                else             len = $urandom_range(25, 64);
                r = $urandom_range(0, 9);
                if (r < 4)       queue_sequence(len, ALPHA_TINY);
                else if (r < 6)  queue_sequence(len, ALPHA_NIBBLE);
                else if (r < 7)  queue_sequence(len, ALPHA_EXTREME);
                else if (r < 8)  queue_sequence(len, ALPHA_FULL);
                else             queue_sequence(len, ALPHA_MIXED);
                queued += len;
            end
            wait_drained();
        end

        // full store: the last two tokens are dropped, the last of them still ends it
        write_reg(REG_QUERY_FIRST, 32'd1);
        write_reg(REG_QUERY_SECOND, 32'd2);
        query_sets++;
        @(negedge i_clk);
        queue_sequence(SEQ_DEPTH + 2, ALPHA_TINY);
        // next sequence must come back with the overflow flag cleared
        queue_token(32'd1, 1'b0);
        queue_token(32'd2, 1'b1);
        wait_drained();

        repeat (20) @(posedge i_clk);
        if (summary_q.size() != 0)
            report_mismatch($sformatf("%0d summaries never arrived", summary_q.size()));

        $display("summary: %0d tokens in %0d sequences under %0d query settings",
                 tokens_sent, seqs_queued, query_sets);
        $display("summary: %0d results checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // watchdog, well beyond the slowest legal run (one full-store search)
    initial begin
        #80_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
